// File: rtl/command_line_argument_splitter_unit_assert.svh
// assertion macros used by the splitter checker
`ifndef COMMAND_LINE_ARGUMENT_SPLITTER_UNIT_ASSERT_SVH
`define COMMAND_LINE_ARGUMENT_SPLITTER_UNIT_ASSERT_SVH

// checked only outside reset
`define CLAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CLAS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/clas_pkg.sv
// constants used by the command line splitter unit
`timescale 1ns / 1ps

package clas_pkg;

  localparam int MAX_RUN = 255;
  localparam int RUN_LIMIT_INT = (MAX_RUN > 255) ? 255 : ((MAX_RUN < 1) ? 1 : MAX_RUN);
  localparam logic [7:0] RUN_LIMIT = RUN_LIMIT_INT[7:0];

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NUL       = 8'h00;

endpackage

// File: rtl/clas_if.sv
// stream interfaces for command line bytes and split results
`timescale 1ns / 1ps

interface clas_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface clas_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] lead_backslashes;
  logic       char_valid;
  logic [7:0] out_char;
  logic       arg_end;
  logic       line_end;
  logic       run_overflow;

  modport source (output valid, output lead_backslashes, output char_valid,
                  output out_char, output arg_end, output line_end,
                  output run_overflow, input ready);
  modport sink (input valid, input lead_backslashes, input char_valid,
                input out_char, input arg_end, input line_end,
                input run_overflow, output ready);
endinterface

// File: rtl/command_line_argument_splitter_unit.sv
// command line splitter: one byte in, at most one split result out
//
//  channel | dir | payload
//  --------+-----+-------------------------------------------------------
//  cmd     | in  | ch
//  res     | out | lead_backslashes, char_valid, out_char, arg_end,
//          |     | line_end, run_overflow
//
// one byte per cycle while res is not stalled; a result shows on res in the cycle after its byte
// the scan state and the result register are the only storage
// cmd.ready is high while the result register is empty or being taken
// synchronous reset clears the scan state and empties the result register
`timescale 1ns / 1ps

module command_line_argument_splitter_unit
  import clas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  clas_in_if.sink    cmd,
  clas_out_if.source res
);

  logic       inside_argument;
  logic       inside_quotes;
  logic [7:0] pending_backslashes;
  logic       overflow_seen;

  logic       inside_argument_next;
  logic       inside_quotes_next;
  logic [7:0] pending_backslashes_next;
  logic       overflow_seen_next;

  logic       emit;
  logic [7:0] lead;
  logic       cv;
  logic [7:0] oc;
  logic       ae;
  logic       le;
  logic       ovf;

  logic       out_valid;
  logic       in_fire;
  logic       is_sep, is_nul, is_bs, is_q, have_run;

  assign cmd.ready = !out_valid || res.ready;
  assign in_fire   = cmd.valid && cmd.ready;

  assign is_sep   = (cmd.ch == CH_SPACE) || (cmd.ch == CH_TAB);
  assign is_nul   = (cmd.ch == CH_NUL);
  assign is_bs    = (cmd.ch == CH_BACKSLASH);
  assign is_q     = (cmd.ch == CH_DQUOTE);
  assign have_run = (pending_backslashes != 8'd0);

  always_comb begin
    inside_argument_next     = inside_argument;
    inside_quotes_next       = inside_quotes;
    pending_backslashes_next = pending_backslashes;
    overflow_seen_next       = overflow_seen;
    emit = 1'b0;
    lead = 8'd0;
    cv   = 1'b0;
    oc   = 8'd0;
    ae   = 1'b0;
    le   = 1'b0;
    ovf  = overflow_seen;
    if (!inside_argument && is_nul) begin
      emit = 1'b1;
      le   = 1'b1;
      inside_quotes_next       = 1'b0;
      pending_backslashes_next = 8'd0;
      overflow_seen_next       = 1'b0;
    end else if (!inside_argument && is_sep) begin
      // skipping whitespace between arguments
    end else begin
      inside_argument_next = 1'b1;
      if (have_run && is_bs) begin
        // saturate the run and remember that it did
        if (pending_backslashes >= RUN_LIMIT) overflow_seen_next = 1'b1;
        else pending_backslashes_next = pending_backslashes + 8'd1;
      end else if (have_run && is_q) begin
        pending_backslashes_next = 8'd0;
        emit = 1'b1;
        lead = {1'b0, pending_backslashes[7:1]};
        if (pending_backslashes[0]) begin
          cv = 1'b1;
          oc = CH_DQUOTE;
        end else begin
          inside_quotes_next = !inside_quotes;
        end
      end else if (!have_run && is_bs) begin
        pending_backslashes_next = 8'd1;
      end else if (!have_run && is_q) begin
        inside_quotes_next = !inside_quotes;
      end else begin
        lead = pending_backslashes;
        pending_backslashes_next = 8'd0;
        emit = 1'b1;
        if (is_nul) begin
          ae = 1'b1;
          le = 1'b1;
          inside_argument_next = 1'b0;
          inside_quotes_next   = 1'b0;
          overflow_seen_next   = 1'b0;
        end else if (is_sep && !inside_quotes) begin
          ae = 1'b1;
          inside_argument_next = 1'b0;
        end else begin
          cv = 1'b1;
          oc = cmd.ch;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_argument     <= 1'b0;
      inside_quotes       <= 1'b0;
      pending_backslashes <= 8'd0;
      overflow_seen       <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (in_fire) begin
        inside_argument     <= inside_argument_next;
        inside_quotes       <= inside_quotes_next;
        pending_backslashes <= pending_backslashes_next;
        overflow_seen       <= overflow_seen_next;
      end
      if (in_fire && emit) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  // result payload, loaded only when a word is produced
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      res.lead_backslashes <= lead;
      res.char_valid       <= cv;
      res.out_char         <= oc;
      res.arg_end          <= ae;
      res.line_end         <= le;
      res.run_overflow     <= ovf;
    end
  end

  assign res.valid = out_valid;

endmodule

// File: rtl/clas_checker.sv
// port-level checks for the command line splitter, bound to the splitter unit
`timescale 1ns / 1ps
`include "command_line_argument_splitter_unit_assert.svh"

module clas_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] lead_backslashes,
  input logic       char_valid,
  input logic [7:0] out_char,
  input logic       arg_end,
  input logic       line_end
);

  // a new result word needs a byte taken on the edge before
  `CLAS_ASSERT(a_out_from_in, $rose(out_valid) |-> $past(in_valid && in_ready), "result without input")

  // an empty output side never stalls the input
  `CLAS_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

  // a stalled result word stays valid and keeps its character and backslash count
  `CLAS_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(lead_backslashes), "stalled result changed")

  // no character means a zero character field
  `CLAS_ASSERT(a_char_zero, out_valid && !char_valid |-> out_char == 8'd0, "stray character")

  // a line end outside an argument carries no backslashes and no character
  `CLAS_ASSERT(a_bare_end, out_valid && line_end && !arg_end |-> lead_backslashes == 8'd0 && !char_valid, "bare line end has payload")

endmodule

bind command_line_argument_splitter_unit clas_checker u_clas_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (cmd.valid),
  .in_ready         (cmd.ready),
  .out_valid        (res.valid),
  .out_ready        (res.ready),
  .lead_backslashes (res.lead_backslashes),
  .char_valid       (res.char_valid),
  .out_char         (res.out_char),
  .arg_end          (res.arg_end),
  .line_end         (res.line_end)
);
